/* hw/rtl/bpc_pkg.sv */
`default_nettype none
package bpc_pkg;
    localparam int unsigned RawW = 24;
    localparam int unsigned WordW = 32;
    localparam int unsigned CfgDataW = 48;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned OssW = 2;
    localparam int unsigned ErrW = 2;

    localparam logic [CfgIdxW-1:0] REG_AC123 = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_AC456 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_B12 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_MCMD = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_OSS = 3'd4;

    localparam logic [ErrW-1:0] ERR_OK = 2'd0;
    localparam logic [ErrW-1:0] ERR_UNCAL = 2'd1;
    localparam logic [ErrW-1:0] ERR_DIV0 = 2'd2;

    localparam logic [OssW-1:0] OSS_RESET = 2'd1;

    // datapath micro-operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_T_X1,
        OP_T_DEN,
        OP_T_B6,
        OP_T_SQ,
        OP_T_B3,
        OP_T_X3,
        OP_T_B4,
        OP_P_B7,
        OP_P_LOAD,
        OP_P_T,
        OP_P_X1,
        OP_P_FIN,
        OP_DIV_LOAD
    } t_op;

    typedef struct packed {
        t_op  op;
        logic div_step;
        logic div_signed;
        logic div_fix;
    } t_cmd;

    typedef struct packed {
        logic den_zero;
        logic b4_zero;
        logic calibrated;
    } t_stat;
endpackage
`default_nettype wire

/* hw/rtl/bpc_if.sv */
`default_nettype none
interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [23:0] raw_reading;
    modport source (output valid, cmd, raw_reading, input ready);
    modport sink (input valid, cmd, raw_reading, output ready);
endinterface

interface bpc_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] pressure_pa;
    logic [1:0]  error_code;
    modport source (output valid, result_kind, pressure_pa, error_code, input ready);
    modport sink (input valid, result_kind, pressure_pa, error_code, output ready);
endinterface
`default_nettype wire

/* hw/rtl/barometric_pressure_compensation.sv */
`default_nettype none
// Barometric pressure compensation.
// Input channel: one beat carries cmd (0 raw temperature, 1 raw pressure)
// and the 24-bit raw sensor word. Output channel: one beat per input beat
// with result_kind, pressure_pa and error_code.
// A temperature beat derives and stores B3/B4; a pressure beat uses them.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 AC1-3, 1 AC4-6, 2 B1/B2, 3 MC/MD, 4 oversampling). Write only when idle.
// From input accept to result valid an item runs through the derivation steps, a
// restoring divider (one quotient bit a cycle) and the multiply steps; an
// error skips the divider and goes straight to the result beat.
// One item is in flight at a time; the next is accepted in the cycle after
// its result beat is taken.
// While the receiver stalls the result holds.
// Reset clears the coefficients, sets oversampling to 1 and clears the
// calibrated flag so pressure beats report "not calibrated".
module barometric_pressure_compensation (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    bpc_in_if.sink                            in_ch,
    bpc_out_if.source                         out_ch,
    input  wire logic                         i_cfg_we,
    input  wire logic [bpc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [bpc_pkg::CfgDataW-1:0] i_cfg_data
);
    logic [47:0] r_ac123, r_ac456;
    logic [31:0] r_b12, r_mcmd;
    logic [1:0] r_oss;
    bpc_pkg::t_cmd ctl;
    bpc_pkg::t_stat stat;
    logic load;
    logic [31:0] pres;

    // register configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac123 <= '0;
            r_ac456 <= '0;
            r_b12 <= '0;
            r_mcmd <= '0;
            r_oss <= bpc_pkg::OSS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpc_pkg::REG_AC123: r_ac123 <= i_cfg_data;
                bpc_pkg::REG_AC456: r_ac456 <= i_cfg_data;
                bpc_pkg::REG_B12: r_b12 <= i_cfg_data[31:0];
                bpc_pkg::REG_MCMD: r_mcmd <= i_cfg_data[31:0];
                bpc_pkg::REG_OSS: r_oss <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    bpc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_cmd(in_ch.cmd), .o_in_ready(in_ch.ready),
        .o_load(load), .i_stat(stat), .o_ctl(ctl), .i_pres(pres),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .o_kind(out_ch.result_kind), .o_pres(out_ch.pressure_pa),
        .o_err(out_ch.error_code)
    );

    bpc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(load), .i_cmd_bit(out_ch.result_kind),
        .i_raw(in_ch.raw_reading), .i_ac123(r_ac123), .i_ac456(r_ac456),
        .i_b12(r_b12), .i_mcmd(r_mcmd), .i_oss(r_oss), .i_ctl(ctl),
        .o_stat(stat), .o_pres(pres)
    );
endmodule
`default_nettype wire

/* hw/rtl/bpc_datapath.sv */
`default_nettype none
module bpc_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_load,
    input  wire logic                           i_cmd_bit,
    input  wire logic [bpc_pkg::RawW-1:0]       i_raw,
    input  wire logic [47:0]                    i_ac123,
    input  wire logic [47:0]                    i_ac456,
    input  wire logic [31:0]                    i_b12,
    input  wire logic [31:0]                    i_mcmd,
    input  wire logic [bpc_pkg::OssW-1:0]       i_oss,
    input  wire bpc_pkg::t_cmd                  i_ctl,
    output bpc_pkg::t_stat                      o_stat,
    output logic [bpc_pkg::WordW-1:0]           o_pres
);
    logic [23:0] r_raw;
    logic signed [31:0] r_x1, r_x2, r_b6, r_sq, r_p, r_acc;
    logic signed [31:0] r_b3;
    logic [31:0] r_b4;
    logic r_cal;
    // divider registers
    logic [31:0] r_rem, r_quo, r_dvs;
    logic r_neg;

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, ac5, ac6, ut;
    logic [31:0] ac4, up, b7;
    logic [32:0] trial;

    assign ac1 = 32'(signed'(i_ac123[47:32]));
    assign ac2 = 32'(signed'(i_ac123[31:16]));
    assign ac3 = 32'(signed'(i_ac123[15:0]));
    assign ac4 = {16'd0, i_ac456[47:32]};
    assign ac5 = {16'd0, i_ac456[31:16]};
    assign ac6 = {16'd0, i_ac456[15:0]};
    assign b1 = 32'(signed'(i_b12[31:16]));
    assign b2 = 32'(signed'(i_b12[15:0]));
    assign mc = 32'(signed'(i_mcmd[31:16]));
    assign md = 32'(signed'(i_mcmd[15:0]));
    assign ut = {16'd0, r_raw[23:8]};
    assign up = 32'({8'd0, r_raw} >> (4'd8 - {2'd0, i_oss}));
    assign b7 = (up - r_b3) * (32'd50000 >> i_oss);
    assign trial = {r_rem[31:0], r_quo[31]} - {1'b0, r_dvs};

    assign o_stat.den_zero = (r_x2 == 32'sd0);
    assign o_stat.b4_zero = (r_b4 == 32'd0);
    assign o_stat.calibrated = r_cal;
    assign o_pres = r_acc;

    // hold calibration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= 1'b0;
            r_b3 <= '0;
            r_b4 <= '0;
        end else if (i_ctl.op == bpc_pkg::OP_T_B4) begin
            r_b4 <= 32'(ac4 * ($unsigned(r_acc) + 32'd32768)) >> 15;
            r_cal <= 1'b1;
        end else if (i_ctl.op == bpc_pkg::OP_T_B3) begin
            r_b3 <= (32'((32'(ac1 * 4) + r_x1 + r_x2) << i_oss) + 32'sd2) >>> 2;
        end
    end

    // sequence arithmetic one step per command
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_raw <= i_raw;
        end
        unique case (i_ctl.op)
            bpc_pkg::OP_T_X1: r_x1 <= 32'((ut - ac6) * ac5) >>> 15;
            bpc_pkg::OP_T_DEN: r_x2 <= r_x1 + md;
            bpc_pkg::OP_DIV_LOAD: begin
                if (i_cmd_bit) begin
                    // unsigned b7 / b4; b7 is doubled first when bit 31 is clear, else the quotient is doubled later
                    r_quo <= b7[31] ? b7 : {b7[30:0], 1'b0};
                    r_p <= {31'd0, b7[31]};
                    r_dvs <= r_b4;
                    r_neg <= 1'b0;
                end else begin
                    r_quo <= mc[31] ? 32'(-(mc <<< 11)) : 32'(mc <<< 11);
                    r_dvs <= r_x2[31] ? 32'(-r_x2) : r_x2;
                    r_neg <= mc[31] ^ r_x2[31];
                end
                r_rem <= '0;
            end
            bpc_pkg::OP_T_B6: r_b6 <= r_x1 + (r_neg ? 32'(-r_quo) : r_quo) - 32'sd4000;
            bpc_pkg::OP_T_SQ: begin
                r_sq <= 32'(r_b6 * r_b6) >>> 12;
                r_x2 <= 32'(ac2 * r_b6) >>> 11;
            end
            bpc_pkg::OP_T_X3: begin
                r_x1 <= 32'(b2 * r_sq) >>> 11;
                r_acc <= 32'(ac3 * r_b6) >>> 13;
            end
            bpc_pkg::OP_T_B3: begin
                r_acc <= ((r_acc + (32'(b1 * r_sq) >>> 16)) + 32'sd2) >>> 2;
            end
            bpc_pkg::OP_P_LOAD: begin
                r_p <= r_p[0] ? 32'(r_quo << 1) : r_quo;
            end
            bpc_pkg::OP_P_T: begin
                r_x1 <= (r_p >>> 8) * (r_p >>> 8);
                r_x2 <= 32'(32'sh0 - 32'sd7357 * r_p) >>> 16;
            end
            bpc_pkg::OP_P_X1: r_x1 <= 32'(r_x1 * 32'sd3038) >>> 16;
            bpc_pkg::OP_P_FIN: r_acc <= r_p + ((r_x1 + r_x2 + 32'sd3791) >>> 4);
            bpc_pkg::OP_P_B7: r_acc <= '0;
            default: begin
                if (i_ctl.div_step) begin
                    // restoring division, one quotient bit per cycle
                    if (!trial[32]) begin
                        r_rem <= trial[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[30:0], r_quo[31]};
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                end
                if (i_ctl.div_fix) r_acc <= '0;
            end
        endcase
    end
endmodule
`default_nettype wire

/* hw/rtl/bpc_ctrl.sv */
`default_nettype none
module bpc_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_cmd,
    output logic                      o_in_ready,
    output logic                      o_load,
    input  wire bpc_pkg::t_stat       i_stat,
    output bpc_pkg::t_cmd             o_ctl,
    input  wire logic [31:0]          i_pres,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_kind,
    output logic [31:0]               o_pres,
    output logic [1:0]                o_err
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PREP = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_POST = 8'b0000_1000,
        S_DONE = 8'b0001_0000,
        S_OUT  = 8'b0010_0000,
        S_CHK  = 8'b0100_0000,
        S_ERR  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [5:0] r_cnt, n_cnt;
    logic r_kind;
    logic [1:0] r_err;
    logic [31:0] r_pres;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_load = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_OUT);
    assign o_kind = r_kind;
    assign o_pres = r_pres;
    assign o_err = r_err;

    // sequence commands
    always_comb begin
        n_state = r_state;
        n_step = r_step;
        n_cnt = r_cnt;
        o_ctl = '{op: bpc_pkg::OP_NONE, div_step: 1'b0, div_signed: 1'b0, div_fix: 1'b0};
        unique case (r_state)
            S_IDLE: if (o_load) begin
                n_state = i_in_cmd ? S_CHK : S_PREP;
                n_step = '0;
            end
            S_CHK: begin
                if (!i_stat.calibrated || i_stat.b4_zero) n_state = S_ERR;
                else begin
                    o_ctl.op = bpc_pkg::OP_DIV_LOAD;
                    n_cnt = 6'd32;
                    n_state = S_DIV;
                end
            end
            S_PREP: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd0) o_ctl.op = bpc_pkg::OP_T_X1;
                else if (r_step == 3'd1) o_ctl.op = bpc_pkg::OP_T_DEN;
                else if (i_stat.den_zero) n_state = S_ERR;
                else begin
                    o_ctl.op = bpc_pkg::OP_DIV_LOAD;
                    n_cnt = 6'd32;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    n_state = S_POST;
                    n_step = '0;
                end
            end
            S_POST: begin
                n_step = r_step + 3'd1;
                if (r_kind) begin
                    unique case (r_step)
                        3'd0: o_ctl.op = bpc_pkg::OP_P_LOAD;
                        3'd1: o_ctl.op = bpc_pkg::OP_P_T;
                        3'd2: o_ctl.op = bpc_pkg::OP_P_X1;
                        default: begin
                            o_ctl.op = bpc_pkg::OP_P_FIN;
                            n_state = S_DONE;
                        end
                    endcase
                end else begin
                    unique case (r_step)
                        3'd0: o_ctl.op = bpc_pkg::OP_T_B6;
                        3'd1: o_ctl.op = bpc_pkg::OP_T_SQ;
                        3'd2: o_ctl.op = bpc_pkg::OP_T_X3;
                        3'd3: o_ctl.op = bpc_pkg::OP_T_B3;
                        default: begin
                            o_ctl.op = bpc_pkg::OP_T_B4;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE: n_state = S_OUT;
            S_ERR: n_state = S_OUT;
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // advance state and hold result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= '0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_step <= n_step;
            r_cnt <= n_cnt;
        end
        if (o_load) begin
            r_kind <= i_in_cmd;
            r_err <= bpc_pkg::ERR_OK;
            r_pres <= '0;
        end else if (r_state == S_ERR) begin
            r_err <= (r_kind && !i_stat.calibrated) ? bpc_pkg::ERR_UNCAL : bpc_pkg::ERR_DIV0;
            r_pres <= '0;
        end else if (r_state == S_DONE) begin
            r_pres <= r_kind ? i_pres : '0;
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(r_pres))
        else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> !o_in_ready)
        else $error("accepted while busy");
    a_temp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_kind |-> r_pres == 32'd0)
        else $error("temperature beat carries pressure");
`endif
endmodule
`default_nettype wire
